// ----- sv/eds_pkg.sv -----
// shared types and constants of the euclidean distance stream block
`timescale 1ns / 1ps

package eds_pkg;

	// fixed field widths
	localparam int VALUE_BITS = 16;
	localparam int SUM_BITS   = 43;
	localparam int DIST_BITS  = 30;

	// saturation ceiling of the running sum
	localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

	// one element pair
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] first_value;
		logic signed [VALUE_BITS-1:0] second_value;
		logic                         last_pair;
	} pair_t;

	// one result
	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic [SUM_BITS-1:0]  squared_sum;
	} result_t;

	// accumulator to root unit: end of a vector pair and its final sum
	typedef struct packed {
		logic                vec_end;
		logic [SUM_BITS-1:0] sum;
	} mac_out_t;

	// root unit control from the top level
	typedef struct packed {
		logic start;
		logic take;
	} sqrt_ctl_t;

	// root unit status to the top level
	typedef struct packed {
		logic idle;
		logic done;
	} sqrt_sts_t;

endpackage

// ----- sv/eds_stream_if.sv -----
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface eds_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/eds_mac.sv -----
// difference, square and saturating accumulate, one pair per cycle
`timescale 1ns / 1ps

module eds_mac #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  eds_pkg::pair_t   in_pair,
	output eds_pkg::mac_out_t mac_o
);

	localparam int RAW_W = (SAMPLE_BITS > eds_pkg::VALUE_BITS) ? SAMPLE_BITS
		: eds_pkg::VALUE_BITS;
	localparam int SQ_W  = 2 * SAMPLE_BITS;
	localparam int ACC_W = ((SQ_W > eds_pkg::SUM_BITS) ? SQ_W : eds_pkg::SUM_BITS) + 1;

	logic [RAW_W-1:0]               a_raw;
	logic [RAW_W-1:0]               b_raw;
	logic signed [SAMPLE_BITS:0]    a_ext;
	logic signed [SAMPLE_BITS:0]    b_ext;
	logic signed [SAMPLE_BITS:0]    diff;
	logic signed [SAMPLE_BITS:0]    diff_neg;
	logic [SAMPLE_BITS-1:0]         mag;

	logic                           valid_s1;
	logic                           last_s1;
	logic [SAMPLE_BITS-1:0]         mag_s1;

	logic                           valid_s2;
	logic                           last_s2;
	logic [SQ_W-1:0]                sq_s2;
	logic [SQ_W-1:0]                sq_c;

	logic [eds_pkg::SUM_BITS-1:0]   running_sum_q;
	logic [ACC_W-1:0]               acc_sum;
	logic [eds_pkg::SUM_BITS-1:0]   sum_next;

	// keep the low SAMPLE_BITS of each element and sign-extend them
	assign a_raw    = RAW_W'($unsigned(in_pair.first_value));
	assign b_raw    = RAW_W'($unsigned(in_pair.second_value));
	assign a_ext    = $signed({a_raw[SAMPLE_BITS-1], a_raw[SAMPLE_BITS-1:0]});
	assign b_ext    = $signed({b_raw[SAMPLE_BITS-1], b_raw[SAMPLE_BITS-1:0]});
	assign diff     = a_ext - b_ext;
	assign diff_neg = -diff;
	assign mag      = diff[SAMPLE_BITS] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];

	// stage 1: magnitude of the difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		last_s1 <= in_pair.last_pair;
	end

	// stage 2: square
	assign sq_c = mag_s1 * mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2   <= sq_c;
		last_s2 <= last_s1;
	end

	// saturating add into the running sum
	assign acc_sum  = ACC_W'(running_sum_q) + ACC_W'(sq_s2);
	assign sum_next = (acc_sum > ACC_W'(eds_pkg::SUM_MAX)) ? eds_pkg::SUM_MAX
		: acc_sum[eds_pkg::SUM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
		end else if (valid_s2) begin
			running_sum_q <= last_s2 ? '0 : sum_next;
		end
	end

	// final sum of a vector pair goes to the root unit
	assign mac_o.vec_end = valid_s2 && last_s2;
	assign mac_o.sum     = sum_next;

endmodule

// ----- sv/eds_sqrt.sv -----
// digit-serial fixed point square root, one root bit per cycle
`timescale 1ns / 1ps

module eds_sqrt #(
	parameter int FRACTION_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  eds_pkg::sqrt_ctl_t           ctl,
	input  logic [eds_pkg::SUM_BITS-1:0] value,
	output eds_pkg::sqrt_sts_t           sts,
	output eds_pkg::result_t             res
);

	localparam int FRAC2 = 2 * FRACTION_BITS;
	localparam int TOTAL = eds_pkg::SUM_BITS + FRAC2;
	localparam int PAIRS = (TOTAL + 1) / 2;
	localparam int SH_W  = 2 * PAIRS;
	localparam int R_W   = PAIRS + 2;
	localparam int CNT_W = $clog2(PAIRS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                   state_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [SH_W-1:0]              shift_q;
	logic [R_W-1:0]               rem_q;
	logic [PAIRS-1:0]             root_q;
	logic [eds_pkg::SUM_BITS-1:0] value_q;

	logic [R_W-1:0]               rem_sh;
	logic [R_W-1:0]               trial;
	logic                         fits;

	// one trial subtraction per cycle on the next two operand bits
	assign rem_sh = {rem_q[R_W-3:0], shift_q[SH_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctl.start) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(PAIRS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ctl.take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// operand shift register, remainder and root
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && ctl.start) begin
			shift_q <= SH_W'(value) << FRAC2;
			rem_q   <= '0;
			root_q  <= '0;
			value_q <= value;
		end else if (state_q == ST_RUN) begin
			shift_q <= shift_q << 2;
			rem_q   <= fits ? (rem_sh - trial) : rem_sh;
			root_q  <= {root_q[PAIRS-2:0], fits};
		end
	end

	assign sts.idle        = state_q == ST_IDLE;
	assign sts.done        = state_q == ST_DONE;
	assign res.distance    = eds_pkg::DIST_BITS'(root_q);
	assign res.squared_sum = value_q;

endmodule

// ----- sv/euclidean_distance_stream_top.sv -----
// top level of the streaming euclidean distance block
//
//   channel   dir   payload                                   role
//   pairs     in    first_value, second_value, last_pair      element pairs
//   results   out   distance, squared_sum                     one per vector pair
//
// element pairs are taken one per cycle while the input gate is open; square and
// accumulate run two stages deep; a last pair drops pairs.ready until its root
//   reaches the output register, after the accumulator and the root recurrence, which
//   yields one root bit per cycle; the root waits while the output register is stalled
// reset clears the running sum and leaves no result pending
// a stalled result waits in the output register while the next vector pair streams in
`timescale 1ns / 1ps

module euclidean_distance_stream_top #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	eds_stream_if.sink    pairs,
	eds_stream_if.source  results
);

	logic                 gate_q;
	logic                 pair_xfer;
	logic                 out_valid_q;
	eds_pkg::result_t     out_q;
	eds_pkg::mac_out_t    mac_o;
	eds_pkg::sqrt_ctl_t   sqrt_ctl;
	eds_pkg::sqrt_sts_t   sqrt_sts;
	eds_pkg::result_t     sqrt_res;

	assign pairs.ready = !gate_q;
	assign pair_xfer   = pairs.valid && !gate_q;

	// accumulator pipeline
	eds_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(pair_xfer),
		.in_pair (pairs.data),
		.mac_o   (mac_o)
	);

	// root unit
	assign sqrt_ctl.start = mac_o.vec_end;
	assign sqrt_ctl.take  = sqrt_sts.done && (!out_valid_q || results.ready);

	eds_sqrt #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (sqrt_ctl),
		.value (mac_o.sum),
		.sts   (sqrt_sts),
		.res   (sqrt_res)
	);

	// input gate: held from a last pair transfer until its root moves into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_q <= 1'b0;
		end else if (pair_xfer && pairs.data.last_pair) begin
			gate_q <= 1'b1;
		end else if (sqrt_ctl.take) begin
			gate_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sqrt_ctl.take) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sqrt_ctl.take) begin
			out_q <= sqrt_res;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

	// with no last pair in flight the root unit holds no finished result
	assert property (@(posedge clk) disable iff (!arst_n) !gate_q |-> !sqrt_sts.done)
		else $error("root unit done with no last pair pending");

	// a vector end only reaches an idle root unit
	assert property (@(posedge clk) disable iff (!arst_n) mac_o.vec_end |-> sqrt_sts.idle)
		else $error("vector end while root unit busy");

	// a moved root is offered on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) sqrt_ctl.take |=> results.valid)
		else $error("result lost after root completion");

	// the gate only closes on a last pair transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(gate_q) |-> $past(pairs.valid && pairs.ready && pairs.data.last_pair))
		else $error("input gate closed without a last pair");

endmodule

// ----- test/testbench.sv -----
// self-checking testbench for the streaming euclidean distance block
`timescale 1ns / 1ps

module testbench;

	localparam int VALUE_BITS    = eds_pkg::VALUE_BITS;
	localparam int SUM_BITS      = eds_pkg::SUM_BITS;
	localparam int DIST_BITS     = eds_pkg::DIST_BITS;
	localparam logic [SUM_BITS-1:0] SUM_MAX = eds_pkg::SUM_MAX;

	localparam int FRAC_BITS     = 8;
	// settle time after the drain; it covers the path from a last pair to its result
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	eds_stream_if #(.payload_t(eds_pkg::pair_t))   pairs ();
	eds_stream_if #(.payload_t(eds_pkg::result_t)) results ();

	euclidean_distance_stream_top #(
		.SAMPLE_BITS  (VALUE_BITS),
		.FRACTION_BITS(FRAC_BITS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.pairs (pairs),
		.results(results)
	);

	// predicted state and pending distances
	logic [SUM_BITS-1:0] acc_sum = '0;
	eds_pkg::result_t    pending_distances[$];
	eds_pkg::result_t    oldest;

	int  error_count     = 0;
	int  pair_count      = 0;
	int  vector_count    = 0;
	int  cur_len         = 0;
	int  longest_vector  = 0;
	int  stall_left      = 0;
	bit  no_idle         = 1'b0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	// floor(sqrt(sum) * 2^FRAC_BITS) by bisection on the root
	function automatic logic [DIST_BITS-1:0] fixed_root(input logic [SUM_BITS-1:0] sum);
		logic [63:0] scaled;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		scaled = {21'd0, sum} << (2 * FRAC_BITS);
		lo = 64'd0;
		hi = 64'd1 << DIST_BITS;
		while (hi - lo > 64'd1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= scaled)
				lo = mid;
			else
				hi = mid;
		end
		return lo[DIST_BITS-1:0];
	endfunction

	// add one squared difference, saturate, and queue a distance on the last pair
	function automatic void accumulate_pair(input eds_pkg::pair_t p);
		logic signed [VALUE_BITS:0] diff;
		logic [VALUE_BITS:0]        mag;
		logic [SUM_BITS:0]          total;
		eds_pkg::result_t           r;
		diff  = $signed(p.first_value) - $signed(p.second_value);
		mag   = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
		total = {1'b0, acc_sum} + mag * mag;
		acc_sum = (total > {1'b0, SUM_MAX}) ? SUM_MAX : total[SUM_BITS-1:0];
		cur_len++;
		if (p.last_pair) begin
			r.distance    = fixed_root(acc_sum);
			r.squared_sum = acc_sum;
			pending_distances.push_back(r);
			if (cur_len > longest_vector)
				longest_vector = cur_len;
			cur_len = 0;
			vector_count++;
			acc_sum = '0;
		end
	endfunction

	// one element pair transfer, then an occasional idle burst
	task automatic send_pair(input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b,
			input logic last);
		eds_pkg::pair_t p;
		p.first_value  = a;
		p.second_value = b;
		p.last_pair    = last;
		pairs.valid <= 1'b1;
		pairs.data  <= p;
		do
			@(posedge clk);
		while (!pairs.ready);
		accumulate_pair(p);
		pair_count++;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			pairs.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// wait for every queued distance, with a limit
	task automatic wait_drained();
		int waited;
		waited = 0;
		while (pending_distances.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 6))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2:       return VALUE_BITS'($urandom_range(0, 15));
			3:       return VALUE_BITS'(-$urandom_range(1, 16));
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	// result sink with random stall bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else if (stall_left > 0) begin
			results.ready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 5) == 0) begin
			results.ready <= 1'b0;
			stall_left    <= $urandom_range(0, 4);
		end else begin
			results.ready <= 1'b1;
		end
	end

	// compare each result transfer with the oldest queued distance
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (pending_distances.size() == 0) begin
				report_mismatch("unexpected result, squared_sum",
					64'(results.data.squared_sum), 64'd0);
			end else begin
				oldest = pending_distances.pop_front();
				if (results.data.distance !== oldest.distance)
					report_mismatch("distance", 64'(results.data.distance),
						64'(oldest.distance));
				if (results.data.squared_sum !== oldest.squared_sum)
					report_mismatch("squared_sum", 64'(results.data.squared_sum),
						64'(oldest.squared_sum));
			end
		end
	end

	// single-pair vectors at the field extremes and at small values
	task automatic test_single_pairs();
		send_pair(16'sd32767, -16'sd32768, 1'b1);
		send_pair(-16'sd32768, 16'sd32767, 1'b1);
		send_pair(16'sd0, 16'sd0, 1'b1);
		send_pair(-16'sd32768, -16'sd32768, 1'b1);
		send_pair(16'sd32767, 16'sd32767, 1'b1);
		send_pair(16'sd1, 16'sd0, 1'b1);
		send_pair(-16'sd1, 16'sd0, 1'b1);
		send_pair(16'sd0, 16'sd2, 1'b1);
	endtask

	// short multi-pair vectors, back to back
	task automatic test_short_vectors();
		send_pair(16'sd3, 16'sd1, 1'b0);
		send_pair(-16'sd4, 16'sd2, 1'b0);
		send_pair(16'sd100, -16'sd100, 1'b1);
		send_pair(16'sd32767, 16'sd0, 1'b0);
		send_pair(16'sd0, -16'sd32768, 1'b0);
		send_pair(-16'sd32768, 16'sd0, 1'b1);
		send_pair(16'sd7, 16'sd7, 1'b0);
		send_pair(-16'sd9, 16'sd3, 1'b1);
	endtask

	// long vector of extreme differences, the sum climbs high into the 43-bit range
	task automatic test_long_vector();
		for (int i = 0; i < 240; i++) begin
			if (i[0])
				send_pair(16'sd32767, -16'sd32768, 1'b0);
			else
				send_pair(-16'sd32768, 16'sd32767, 1'b0);
		end
		send_pair(16'sd32767, -16'sd32768, 1'b1);
		// the sum must start from zero again
		send_pair(16'sd5, 16'sd2, 1'b1);
	endtask

	// sender holds off until every distance has come out
	task automatic test_drain_pause();
		send_pair(16'sd12, -16'sd30, 1'b0);
		send_pair(16'sd40, 16'sd1, 1'b1);
		pairs.valid <= 1'b0;
		wait_drained();
		send_pair(-16'sd500, 16'sd250, 1'b1);
	endtask

	// random vectors, mostly short, a few longer
	task automatic test_random_vectors(input int item_budget);
		int sent;
		int len;
		logic [VALUE_BITS-1:0] a;
		logic [VALUE_BITS-1:0] b;
		sent = 0;
		while (sent < item_budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				a = pick_value();
				b = ($urandom_range(0, 7) == 0) ? a : pick_value();
				send_pair(a, b, i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		pairs.valid <= 1'b0;
		pairs.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_pairs();
		test_short_vectors();
		test_drain_pause();
		test_long_vector();
		test_random_vectors(270);
		// closing stretch at full rate on both sides
		no_idle = 1'b1;
		test_random_vectors(120);

		pairs.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_distances.size() != 0)
			report_mismatch("distances never delivered", 64'(pending_distances.size()),
				64'd0);

		$display("sent %0d element pairs forming %0d vector pairs", pair_count, vector_count);
		$display("longest vector pair held %0d elements", longest_vector);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run time limit
	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
